FILE: rtl/tsbs_pkg.sv
// Shared types, constants and helper functions for the texture store sampler.
// Used by the controller, the datapath and the top level; depends on nothing.
package tsbs_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_NEAREST = 2'd1;

    localparam logic [1:0] LAYOUT_GREY = 2'd0;
    localparam logic [1:0] LAYOUT_RGB  = 2'd1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LAYOUT = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic       capture;   // register the accepted input word
        logic       wrap;      // one step of the coordinate remainder
        logic [1:0] wstep;
        logic       setup;     // compute wrapped indices and fractions
        logic       fetch;     // issue one memory access
        logic [1:0] tap;       // which neighbor is being fetched
        logic       blend;     // one blend step
        logic [1:0] bstep;
        logic       finish;    // load the output register
    } tsbs_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] op;
    } tsbs_stat_t;

    // Q1.12 to byte: min(floor(c * 255 / 4096), 255).
    function automatic logic [7:0] to_byte(input logic [12:0] c);
        logic [20:0] p;
        begin
            p = {8'd0, c} * 21'd255;
            to_byte = (p[20:12] > 9'd255) ? 8'd255 : p[19:12];
        end
    endfunction

endpackage

FILE: rtl/tsbs_ctrl.sv
// Sequencer for the texture store sampler.
// Depends on tsbs_pkg for the command and status structs.
module tsbs_ctrl
    import tsbs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  tsbs_stat_t stat,
    output tsbs_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_WRAP  = 8'b00000010,
        ST_SETUP = 8'b00000100,
        ST_FETCH = 8'b00001000,
        ST_WAIT  = 8'b00010000,
        ST_BLEND = 8'b00100000,
        ST_DONE  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       mv_reg, mv_next;
    logic       out_free;

    // The output register frees when empty or being taken.
    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        cmd.tap    = cnt_reg;
        cmd.bstep  = cnt_reg;
        cmd.wstep  = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = 2'd0;
                    state_next  = ST_WRAP;
                end
            end
            ST_WRAP: begin
                cmd.wrap = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                cnt_next   = 2'd0;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
                cnt_next  = cnt_reg + 2'd1;
                if (stat.op == OP_WRITE || stat.op == OP_NEAREST || cnt_reg == 2'd3) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                cnt_next   = 2'd0;
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                cmd.blend = 1'b1;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

FILE: rtl/tsbs_dp.sv
// Datapath of the texture store sampler: texel memory, address arithmetic and blender.
// Depends on tsbs_pkg; driven by tsbs_ctrl commands.
module tsbs_dp
    import tsbs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  tsbs_cmd_t   cmd,
    output tsbs_stat_t  stat,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_coord_x,
    input  logic [15:0] s_coord_y,
    input  logic [12:0] s_red_in,
    input  logic [12:0] s_green_in,
    input  logic [12:0] s_blue_in,
    input  logic [12:0] s_alpha_in,
    output logic [15:0] m_red_out,
    output logic [15:0] m_green_out,
    output logic [15:0] m_blue_out,
    output logic [15:0] m_alpha_out,
    output logic        m_range_error
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] mem [DEPTH];

    logic [8:0]  wid_reg, hgt_reg;
    logic [1:0]  lay_reg;
    logic [8:0]  w_eff, h_eff;
    logic [1:0]  op_reg;
    logic [15:0] cx_reg, cy_reg;
    logic [15:0] rx_reg, ry_reg;
    logic [15:0] rx_next, ry_next;
    logic [7:0]  r_reg, g_reg, b_reg, a_reg;
    logic [8:0]  x0_reg, x1_reg, y0_reg, y1_reg;
    logic [15:0] fx_reg, fy_reg;
    logic        oob_reg;
    logic [31:0] rd_reg;
    logic        rd_valid_reg;
    logic [1:0]  rd_tap_reg;
    logic [7:0]  tex_reg [4][4];
    logic [24:0] top_reg [4], bot_reg [4];
    logic [15:0] res_reg [4];
    logic        is_write;

    // Effective size: zero acts as one, clipped to the maximum.
    always_comb begin
        w_eff = (wid_reg == 9'd0) ? 9'd1 :
                ({{(32-9){1'b0}}, wid_reg} > MAX_WIDTH) ? 9'(MAX_WIDTH) : wid_reg;
        h_eff = (hgt_reg == 9'd0) ? 9'd1 :
                ({{(32-9){1'b0}}, hgt_reg} > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : hgt_reg;
    end

    assign stat.op  = op_reg;
    assign is_write = (op_reg == OP_WRITE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wid_reg <= 9'd256;
            hgt_reg <= 9'd256;
            lay_reg <= LAYOUT_RGB;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH:  wid_reg <= cfg_data;
                REG_HEIGHT: hgt_reg <= cfg_data;
                REG_LAYOUT: lay_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Capture the input word and convert colors.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= s_operation;
            cx_reg <= s_coord_x;
            cy_reg <= s_coord_y;
            r_reg  <= to_byte(s_red_in);
            g_reg  <= to_byte(s_green_in);
            b_reg  <= to_byte(s_blue_in);
            a_reg  <= to_byte(s_alpha_in);
        end
    end

    // Four restoring steps of the remainder by the texture size. Over the wrap
    // steps the shifts run from 15 down to 0, leaving the value below size.
    function automatic logic [15:0] wrap4(input logic [15:0] v, input logic [8:0] s,
                                          input logic [1:0] step);
        logic [24:0] r, d;
        int          sh;
        begin
            r = {9'd0, v};
            for (int i = 0; i < 4; i++) begin
                sh = 15 - 4 * int'(step) - i;
                d  = {16'd0, s} << sh;
                if (r >= d) r = r - d;
            end
            wrap4 = r[15:0];
        end
    endfunction

    always_comb begin
        rx_next = wrap4(rx_reg, w_eff, cmd.wstep);
        ry_next = wrap4(ry_reg, h_eff, cmd.wstep);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rx_reg <= s_coord_x;
            ry_reg <= s_coord_y;
        end else if (cmd.wrap) begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    logic [24:0] tx, ty;
    logic [8:0]  ix, iy;
    always_comb begin
        tx = 25'(cx_reg) * 25'(w_eff) + 25'd32768;
        ty = 25'(cy_reg) * 25'(h_eff) + 25'd32768;
        ix = tx[24:16];
        iy = ty[24:16];
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            oob_reg <= ({7'd0, w_eff} <= cx_reg) || ({7'd0, h_eff} <= cy_reg);
            if (op_reg == OP_WRITE) begin
                x0_reg <= cx_reg[8:0];
                y0_reg <= cy_reg[8:0];
            end else if (op_reg == OP_NEAREST) begin
                x0_reg <= rx_reg[8:0];
                y0_reg <= ry_reg[8:0];
            end else begin
                // ix is floor+1 in [0, size]; lo = ix-1 wrapped, hi = ix wrapped.
                x0_reg <= (ix == 9'd0) ? w_eff - 9'd1 : ix - 9'd1;
                x1_reg <= (ix == w_eff) ? 9'd0 : ix;
                y0_reg <= (iy == 9'd0) ? h_eff - 9'd1 : iy - 9'd1;
                y1_reg <= (iy == h_eff) ? 9'd0 : iy;
            end
            fx_reg <= tx[15:0];
            fy_reg <= ty[15:0];
        end
    end

    // Address of the current tap: x + (h-1-y)*w.
    logic [8:0]  ax, ay;
    logic [17:0] addr_full;
    logic [AW-1:0] addr;
    always_comb begin
        ax = cmd.tap[0] ? x1_reg : x0_reg;
        ay = cmd.tap[1] ? y1_reg : y0_reg;
        addr_full = 18'(h_eff - 9'd1 - ay) * 18'(w_eff) + 18'(ax);
        addr = AW'(addr_full);
    end

    logic [31:0] wr_word;
    always_comb begin
        wr_word = rd_reg;
        wr_word[7:0] = r_reg;
        if (lay_reg != LAYOUT_GREY) begin
            wr_word[15:8]  = g_reg;
            wr_word[23:16] = b_reg;
        end
        if (lay_reg[1]) wr_word[31:24] = a_reg;
    end

    // Writes read the old word first, then store the merged word in the next cycle.
    logic          wpend_reg;
    logic [AW-1:0] waddr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpend_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            wpend_reg    <= cmd.fetch && is_write && !oob_reg;
            rd_valid_reg <= cmd.fetch;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            rd_reg     <= mem[addr];
            rd_tap_reg <= cmd.tap;
            waddr_reg  <= addr;
        end
        if (wpend_reg) begin
            mem[waddr_reg] <= wr_word;
        end
    end

    // Unpack returned words into channel bytes.
    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            tex_reg[rd_tap_reg][0] <= rd_reg[7:0];
            tex_reg[rd_tap_reg][1] <= (lay_reg == LAYOUT_GREY) ? rd_reg[7:0] : rd_reg[15:8];
            tex_reg[rd_tap_reg][2] <= (lay_reg == LAYOUT_GREY) ? rd_reg[7:0] : rd_reg[23:16];
            tex_reg[rd_tap_reg][3] <= lay_reg[1] ? rd_reg[31:24] : 8'd255;
        end
    end

    // Blend: step 0 horizontal on both rows, step 1 vertical, step 2 done.
    logic [16:0] fxc, fyc;
    assign fxc = 17'd65536 - 17'(fx_reg);
    assign fyc = 17'd65536 - 17'(fy_reg);
    logic [24:0] vt [4];
    logic [41:0] vv [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            vt[k] = 25'(tex_reg[0][k]) * 25'(fxc) + 25'(tex_reg[1][k]) * 25'(fx_reg);
            vv[k] = 42'(top_reg[k]) * 42'(fyc) + 42'(bot_reg[k]) * 42'(fy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.blend) begin
            for (int k = 0; k < 4; k++) begin
                if (cmd.bstep == 2'd0) begin
                    top_reg[k] <= vt[k];
                    bot_reg[k] <= 25'(tex_reg[2][k]) * 25'(fxc)
                                + 25'(tex_reg[3][k]) * 25'(fx_reg);
                end else if (cmd.bstep == 2'd1) begin
                    res_reg[k] <= vv[k][39:24];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_range_error <= is_write && oob_reg;
            if (is_write) begin
                m_red_out <= '0; m_green_out <= '0; m_blue_out <= '0; m_alpha_out <= '0;
            end else if (op_reg == OP_NEAREST) begin
                m_red_out   <= {tex_reg[0][0], 8'd0};
                m_green_out <= {tex_reg[0][1], 8'd0};
                m_blue_out  <= {tex_reg[0][2], 8'd0};
                m_alpha_out <= {tex_reg[0][3], 8'd0};
            end else begin
                m_red_out   <= res_reg[0];
                m_green_out <= res_reg[1];
                m_blue_out  <= res_reg[2];
                m_alpha_out <= res_reg[3];
            end
        end
    end

endmodule

FILE: rtl/texture_store_bilinear_sampler.sv
// Channel   | ports                                   | direction
// s_        | s_valid s_ready + input fields          | in
// m_        | m_valid m_ready + result fields         | out
// cfg_      | cfg_valid cfg_ready cfg_index cfg_data  | in
// A word passes through the wrap, setup, fetch (one memory access, or one per
// neighbor for bilinear), wait, blend, done and out states; m_valid rises once
// the out state loads the result, and a new word is taken only after that.
// The single-port texel memory and the read-modify-write for stores set this.
// Reset (aresetn low, synchronous) restores size 256x256 and rgb layout;
// texel contents stay undefined until written. A stalled output holds the block.
module texture_store_bilinear_sampler
    import tsbs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_coord_x,
    input  logic [15:0] s_coord_y,
    input  logic [12:0] s_red_in,
    input  logic [12:0] s_green_in,
    input  logic [12:0] s_blue_in,
    input  logic [12:0] s_alpha_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_red_out,
    output logic [15:0] m_green_out,
    output logic [15:0] m_blue_out,
    output logic [15:0] m_alpha_out,
    output logic        m_range_error
);

    tsbs_cmd_t  cmd;
    tsbs_stat_t stat;

    assign cfg_ready = 1'b1;

    tsbs_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .stat, .cmd
    );

    tsbs_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .aclk, .aresetn, .cfg_valid, .cfg_index, .cfg_data, .cmd, .stat,
        .s_operation, .s_coord_x, .s_coord_y, .s_red_in, .s_green_in,
        .s_blue_in, .s_alpha_in, .m_red_out, .m_green_out, .m_blue_out,
        .m_alpha_out, .m_range_error
    );

endmodule

FILE: rtl/tsbs_checker.sv
// Port-level checks for the texture store sampler.
// Bound to texture_store_bilinear_sampler; depends on nothing else.
module tsbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_range_error,
    input logic [15:0] m_red_out
);

    // An accepted word blocks new input until its result is loaded.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second word taken early");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out))
        else $error("result changed while stalled");

    // A range error only comes with a write, whose colors are zero.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_red_out == 16'd0)
        else $error("range error with nonzero color");

    a_no_out_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid || $past(m_valid))
        else $error("result appeared too soon");

endmodule

bind texture_store_bilinear_sampler tsbs_checker u_tsbs_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_range_error, .m_red_out
);
